>>> rtl/lps_pkg.sv
package lps_pkg;

    // Fixed geometry of the LED table and of the item fields.
    localparam int NUM_LEDS   = 13;
    localparam int NUM_GROUPS = 5;
    localparam int COLS_W     = 4;
    localparam int ROWS_W     = 8;
    localparam int BASE_W     = 10;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 10;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 50;

    // Packed configuration register widths.
    localparam int COLS_REG_W = NUM_GROUPS * COLS_W;
    localparam int ROWS_REG_W = NUM_GROUPS * ROWS_W;
    localparam int BASE_REG_W = NUM_GROUPS * BASE_W;

    // Widest raw table address: base + (cols + 1) * row + cols.
    localparam int SUM_W      = 13;
    // LED index runs over the columns of all groups.
    localparam int LED_IDX_W  = 7;
    // Group counter also holds the end value NUM_GROUPS.
    localparam int GRP_W      = 3;

    // Defaults for the top-level parameters.
    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int PWM_LEVELS_DEF = 16;

    // Item actions.
    typedef logic [ACT_W-1:0] act_t;
    localparam act_t ACT_WRITE = 2'd0;
    localparam act_t ACT_PWM   = 2'd1;
    localparam act_t ACT_FRAME = 2'd2;
    localparam act_t ACT_NONE  = 2'd3;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_COLS = 2'd0;
    localparam cfg_idx_t CFG_ROWS = 2'd1;
    localparam cfg_idx_t CFG_BASE = 2'd2;

endpackage

>>> rtl/led_pattern_pwm_sequencer.sv
// LED pattern PWM sequencer: drives 13 LEDs from an animation table held in a byte-wide
// pattern memory, split into five groups configured by the cols_cfg_reg, rows_cfg_reg and
// base_cfg_reg registers. A write item stores one pattern byte, a pwm tick steps the PWM
// counter and refreshes each enabled group's LEDs from its row's brightness bytes, and a
// frame tick steps each enabled group's hold counter and row. Every item returns one
// transfer with the LED state. One item is in work at a time and s_ready is low meanwhile;
// a finished result may wait in the output register while the next item is taken. Table
// addresses are reduced modulo MEM_DEPTH by a shared compare-and-subtract unit in
// R = max(13 - log2(MEM_DEPTH), 0) + 1 steps (4 at the default depth), and each pattern
// byte is fetched by a registered memory read. A write item passes through the reduction,
// the memory write and the hand-over; an unused action goes straight to the hand-over.
// A pwm tick walks the groups, reducing each enabled group's row address and then reading
// one byte per column; a frame tick reduces it, then reads and compares the hold byte.
module led_pattern_pwm_sequencer #(
    parameter int MEM_DEPTH  = lps_pkg::MEM_DEPTH_DEF,
    parameter int PWM_LEVELS = lps_pkg::PWM_LEVELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lps_pkg::ACT_W-1:0]     s_action,
    input  logic [lps_pkg::ADDR_W-1:0]    s_addr,
    input  logic [lps_pkg::BYTE_W-1:0]    s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lps_pkg::NUM_LEDS-1:0]  m_led_bits,
    input  logic                          cfg_wr_en,
    input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lps_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = $clog2(PWM_LEVELS);
    localparam int RS = (lps_pkg::SUM_W > AW) ? (lps_pkg::SUM_W - AW) : 0;
    localparam int CW = AW + RS + 1;
    localparam int KW = (RS > 0) ? $clog2(RS + 1) : 1;
    localparam int GW = lps_pkg::GRP_W;
    localparam int LW = lps_pkg::LED_IDX_W;
    localparam int BW = lps_pkg::BYTE_W;
    localparam int NG = lps_pkg::NUM_GROUPS;
    localparam int NL = lps_pkg::NUM_LEDS;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_GRP      = 4'd1;
    localparam logic [3:0] ST_RED      = 4'd2;
    localparam logic [3:0] ST_WR       = 4'd3;
    localparam logic [3:0] ST_COL_RD   = 4'd4;
    localparam logic [3:0] ST_COL_CMP  = 4'd5;
    localparam logic [3:0] ST_HOLD_ADJ = 4'd6;
    localparam logic [3:0] ST_HOLD_RD  = 4'd7;
    localparam logic [3:0] ST_HOLD_CMP = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0]                          state_reg, state_next;
    logic [lps_pkg::COLS_REG_W-1:0]      cols_cfg_reg;
    logic [lps_pkg::ROWS_REG_W-1:0]      rows_cfg_reg;
    logic [lps_pkg::BASE_REG_W-1:0]      base_cfg_reg;
    lps_pkg::act_t                       act_reg, act_next;
    logic [BW-1:0]                       data_reg, data_next;
    logic [PW-1:0]                       pwm_reg, pwm_next;
    logic [GW-1:0]                       g_reg, g_next;
    logic [lps_pkg::COLS_W-1:0]          c_reg, c_next;
    logic [KW-1:0]                       k_reg, k_next;
    logic [CW-1:0]                       v_reg, v_next;
    logic [AW-1:0]                       ptr_reg, ptr_next;
    logic [LW-1:0]                       led_idx_reg, led_idx_next;
    logic [NL-1:0]                       led_reg, led_next;
    logic [lps_pkg::ROWS_W-1:0]          row_reg [NG];
    logic [lps_pkg::ROWS_W-1:0]          row_next [NG];
    logic [BW-1:0]                       hold_reg [NG];
    logic [BW-1:0]                       hold_next [NG];
    logic                                m_valid_reg, m_valid_next;
    logic [NL-1:0]                       m_led_reg, m_led_next;

    logic                                mem_wr_en;
    logic [BW-1:0]                       mem_rd_data;

    // Fields of the current group.
    logic [lps_pkg::COLS_W-1:0]          cur_cols;
    logic [lps_pkg::ROWS_W-1:0]          cur_rows;
    logic [lps_pkg::BASE_W-1:0]          cur_base;
    logic [lps_pkg::ROWS_W-1:0]          cur_row;
    logic [lps_pkg::COLS_W:0]            cols_p1;
    logic [lps_pkg::SUM_W-1:0]           start_raw;

    // Shared compare-and-subtract unit and pointer arithmetic.
    logic [CW-1:0]                       divisor;
    logic [CW-1:0]                       red_val;
    logic [AW:0]                         ptr_inc;
    logic [AW:0]                         ptr_hold;
    logic [NL-1:0]                       led_sel;
    logic [lps_pkg::ROWS_W:0]            rows_ext;
    logic [lps_pkg::ROWS_W:0]            row_inc;

    assign cur_cols  = cols_cfg_reg[g_reg * lps_pkg::COLS_W +: lps_pkg::COLS_W];
    assign cur_rows  = rows_cfg_reg[g_reg * lps_pkg::ROWS_W +: lps_pkg::ROWS_W];
    assign cur_base  = base_cfg_reg[g_reg * lps_pkg::BASE_W +: lps_pkg::BASE_W];
    assign cur_row   = row_reg[g_reg];
    assign cols_p1   = (lps_pkg::COLS_W + 1)'(cur_cols) + 1'b1;
    assign start_raw = lps_pkg::SUM_W'(cur_base)
                     + lps_pkg::SUM_W'(cols_p1 * cur_row);

    assign divisor = CW'(MEM_DEPTH) << k_reg;
    assign red_val = (v_reg >= divisor) ? (v_reg - divisor) : v_reg;

    assign ptr_inc  = (AW + 1)'(ptr_reg) + 1'b1;
    assign ptr_hold = (AW + 1)'(ptr_reg) + (AW + 1)'(cur_cols);

    assign rows_ext = (cur_rows == '0) ? (lps_pkg::ROWS_W + 1)'(256)
                                       : (lps_pkg::ROWS_W + 1)'(cur_rows);
    assign row_inc  = (lps_pkg::ROWS_W + 1)'(cur_row) + 1'b1;

    // One-hot select of the LED addressed by the running index.
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            led_sel[i] = (led_idx_reg == LW'(i));
        end
    end

    assign mem_wr_en = (state_reg == ST_WR);

    lps_pattern_mem #(
        .DEPTH(MEM_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (data_reg),
        .rd_addr (ptr_reg),
        .rd_data (mem_rd_data)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= '0;
            rows_cfg_reg <= '0;
            base_cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lps_pkg::CFG_COLS: cols_cfg_reg <= cfg_wdata[lps_pkg::COLS_REG_W-1:0];
                lps_pkg::CFG_ROWS: rows_cfg_reg <= cfg_wdata[lps_pkg::ROWS_REG_W-1:0];
                lps_pkg::CFG_BASE: base_cfg_reg <= cfg_wdata[lps_pkg::BASE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        data_next    = data_reg;
        pwm_next     = pwm_reg;
        g_next       = g_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        v_next       = v_reg;
        ptr_next     = ptr_reg;
        led_idx_next = led_idx_reg;
        led_next     = led_reg;
        row_next     = row_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        m_led_next   = m_led_reg;

        // The output register empties on a transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next     = s_action;
                    data_next    = s_data;
                    g_next       = '0;
                    led_idx_next = '0;
                    unique case (s_action)
                        lps_pkg::ACT_WRITE: begin
                            v_next     = CW'(s_addr);
                            k_next     = KW'(RS);
                            state_next = ST_RED;
                        end
                        lps_pkg::ACT_PWM: begin
                            if (pwm_reg >= PW'(PWM_LEVELS - 1)) begin
                                pwm_next = '0;
                            end else begin
                                pwm_next = pwm_reg + 1'b1;
                            end
                            state_next = ST_GRP;
                        end
                        lps_pkg::ACT_FRAME: begin
                            state_next = ST_GRP;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Walk the groups; a disabled group is skipped.
            ST_GRP: begin
                if (g_reg == GW'(NG)) begin
                    state_next = ST_DONE;
                end else if (cur_cols == '0) begin
                    g_next = g_reg + 1'b1;
                end else begin
                    v_next     = CW'(start_raw);
                    k_next     = KW'(RS);
                    c_next     = '0;
                    state_next = ST_RED;
                end
            end

            // Reduce the address modulo the memory depth, one shifted divisor per cycle.
            ST_RED: begin
                v_next = red_val;
                if (k_reg == '0) begin
                    ptr_next = red_val[AW-1:0];
                    unique case (act_reg)
                        lps_pkg::ACT_WRITE: state_next = ST_WR;
                        lps_pkg::ACT_PWM:   state_next = ST_COL_RD;
                        default:            state_next = ST_HOLD_ADJ;
                    endcase
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end

            ST_WR: begin
                state_next = ST_DONE;
            end

            // Memory read of one brightness byte is under way.
            ST_COL_RD: begin
                state_next = ST_COL_CMP;
            end

            // Light the LED while the PWM count is below its brightness.
            ST_COL_CMP: begin
                if (BW'(pwm_reg) < mem_rd_data) begin
                    led_next = led_reg | led_sel;
                end else begin
                    led_next = led_reg & ~led_sel;
                end
                led_idx_next = led_idx_reg + 1'b1;
                ptr_next     = (ptr_inc == (AW + 1)'(MEM_DEPTH)) ? '0 : ptr_inc[AW-1:0];
                c_next       = c_reg + 1'b1;
                if (c_reg == cur_cols - 1'b1) begin
                    g_next     = g_reg + 1'b1;
                    state_next = ST_GRP;
                end else begin
                    state_next = ST_COL_RD;
                end
            end

            // The hold byte follows the row's brightness bytes.
            ST_HOLD_ADJ: begin
                if (ptr_hold >= (AW + 1)'(MEM_DEPTH)) begin
                    ptr_next = AW'(ptr_hold - (AW + 1)'(MEM_DEPTH));
                end else begin
                    ptr_next = ptr_hold[AW-1:0];
                end
                state_next = ST_HOLD_RD;
            end

            ST_HOLD_RD: begin
                state_next = ST_HOLD_CMP;
            end

            // Step the row once the hold count matches, otherwise count on.
            ST_HOLD_CMP: begin
                if (hold_reg[g_reg] == mem_rd_data) begin
                    hold_next[g_reg] = '0;
                    if (row_inc >= rows_ext) begin
                        row_next[g_reg] = '0;
                    end else begin
                        row_next[g_reg] = row_inc[lps_pkg::ROWS_W-1:0];
                    end
                end else begin
                    hold_next[g_reg] = hold_reg[g_reg] + 1'b1;
                end
                g_next     = g_reg + 1'b1;
                state_next = ST_GRP;
            end

            // Hand the result over once the output register is free.
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_led_next   = led_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pwm_reg     <= '0;
            led_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NG; i++) begin
                row_reg[i]  <= '0;
                hold_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            pwm_reg     <= pwm_next;
            led_reg     <= led_next;
            m_valid_reg <= m_valid_next;
            row_reg     <= row_next;
            hold_reg    <= hold_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        data_reg    <= data_next;
        g_reg       <= g_next;
        c_reg       <= c_next;
        k_reg       <= k_next;
        v_reg       <= v_next;
        ptr_reg     <= ptr_next;
        led_idx_reg <= led_idx_next;
        m_led_reg   <= m_led_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_led_bits = m_led_reg;

endmodule

>>> rtl/lps_pattern_mem.sv
module lps_pattern_mem #(
    parameter int DEPTH = lps_pkg::MEM_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [lps_pkg::BYTE_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [lps_pkg::BYTE_W-1:0] rd_data
);

    logic [lps_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [lps_pkg::BYTE_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lps_checker.sv
module lps_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [lps_pkg::ACT_W-1:0]     s_action,
    input logic [lps_pkg::ADDR_W-1:0]    s_addr,
    input logic [lps_pkg::BYTE_W-1:0]    s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [lps_pkg::NUM_LEDS-1:0]  m_led_bits,
    input logic                          cfg_wr_en,
    input logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [lps_pkg::CFG_W-1:0]     cfg_wdata
);

    // A reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result pending right after reset");

    // After an input transfer the block is busy with that item.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again in the cycle after a transfer");

    // No result can show up in the cycle right after its item was taken.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_led_bits)))
        else $error("stalled result changed");

endmodule

bind led_pattern_pwm_sequencer lps_checker u_lps_checker (.*);
